// File: sv/fir_fd_pkg.sv
`default_nettype none

package fir_fd_pkg;

  localparam int unsigned TAP_COUNT_W  = 10;
  localparam int unsigned RATE_STEP_W  = 27;
  localparam int unsigned COEF_INDEX_W = 9;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = RATE_STEP_W;

  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_STEP = 1'b1;

  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 10'd351;
  localparam logic [RATE_STEP_W-1:0] RATE_STEP_RST = 27'd6826667;

  localparam int unsigned PHASE_W = 28;
  localparam logic [PHASE_W-1:0] PHASE_ONE = 28'h001_0000;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    CMD_COEF   = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_EMIT   = 2'd2
  } cmd_kind_e;

  typedef enum logic [1:0] {
    B_IDLE  = 2'd0,
    B_MAC   = 2'd1,
    B_DRAIN = 2'd2,
    B_ROUND = 2'd3
  } back_state_e;

endpackage

`default_nettype wire

// File: sv/fir_fd_ram.sv
`default_nettype none

module fir_fd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: sv/fir_fd_queue.sv
`default_nettype none

module fir_fd_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// File: sv/fir_fd_front.sv
`default_nettype none

module fir_fd_front
  import fir_fd_pkg::*;
#(
  parameter int unsigned MAX_TAPS = 512
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push_i,
  input  wire logic                    full_i,
  input  wire logic                    req_type_i,
  input  wire logic [COEF_INDEX_W-1:0] coef_index_i,
  input  wire logic [RATE_STEP_W-1:0]  rate_step_i,
  output logic                         cmd_push_o,
  output cmd_kind_e                    cmd_kind_o
);

  logic               accept, emit, idx_ok;
  logic [PHASE_W-1:0] phase_q, phase_d, phase_sum;

  assign accept = push_i && !full_i;
  assign emit   = (phase_q < PHASE_ONE);
  assign idx_ok = (32'(coef_index_i) < 32'(MAX_TAPS));

  always_comb begin
    phase_sum = emit ? phase_q + PHASE_W'(rate_step_i) : phase_q;
    phase_d   = phase_q;
    if (accept && req_type_i) begin
      phase_d = (phase_sum >= PHASE_ONE) ? phase_sum - PHASE_ONE : '0;
    end
  end

  always_comb begin
    if (req_type_i) begin
      cmd_kind_o = emit ? CMD_EMIT : CMD_SAMPLE;
      cmd_push_o = accept;
    end else begin
      cmd_kind_o = CMD_COEF;
      cmd_push_o = accept && idx_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/fir_fd_back.sv
`default_nettype none

module fir_fd_back
  import fir_fd_pkg::*;
#(
  parameter int unsigned MAX_TAPS    = 512,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COEF_BITS   = 18
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cmd_valid_i,
  input  wire cmd_kind_e                     cmd_kind_i,
  input  wire logic [COEF_INDEX_W-1:0]       cmd_index_i,
  input  wire logic signed [COEF_BITS-1:0]   cmd_coef_i,
  input  wire logic signed [SAMPLE_BITS-1:0] cmd_sample_i,
  output logic                               cmd_pop_o,
  input  wire logic [TAP_COUNT_W-1:0]        tap_count_i,
  input  wire logic                          pop_i,
  output logic                               empty_o,
  output logic signed [SAMPLE_BITS-1:0]      sample_out_o,
  output logic                               saturated_o
);

  localparam int unsigned AW   = $clog2(MAX_TAPS);
  localparam int unsigned NW   = $clog2(MAX_TAPS + 1);
  localparam int unsigned TW   = (NW > TAP_COUNT_W) ? NW : TAP_COUNT_W;
  localparam int unsigned SW   = AW + 1;
  localparam int unsigned PW   = SAMPLE_BITS + COEF_BITS;
  localparam int unsigned ACCW = SAMPLE_BITS + COEF_BITS + AW;
  localparam int unsigned RW   = ACCW - COEF_BITS + 1;
  localparam int unsigned HW   = RW - SAMPLE_BITS + 1;

  back_state_e state_q, state_d;

  logic [AW-1:0] wp_q, wp_d, rd_q, rd_d, ci_q, ci_d;
  logic [NW-1:0] cnt_q, cnt_d, taps;
  logic          wrap_q, wrap_d;
  logic          v1_q, v1_d, m1_q, m1_d, v2_q, v2_d;
  logic          res_q, res_d, load;
  logic [SW-1:0] start_sum;
  logic [AW-1:0] start;

  logic signed [PW-1:0]   prod_q, prod_d;
  logic signed [ACCW-1:0] acc_q, acc_d, rnd;
  logic [RW-1:0]          rs;
  logic [HW-1:0]          rs_top;
  logic                   sat_pos, sat_neg;
  logic [SAMPLE_BITS-1:0] out_d;

  logic                   dl_we, cf_we, issue;
  logic [SAMPLE_BITS-1:0] dl_rdata;
  logic [COEF_BITS-1:0]   cf_rdata;

  fir_fd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_delay (
    .clk_i,
    .we_i   (dl_we),
    .waddr_i(wp_q),
    .wdata_i(cmd_sample_i),
    .raddr_i(rd_q),
    .rdata_o(dl_rdata)
  );

  fir_fd_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_TAPS)) u_coef (
    .clk_i,
    .we_i   (cf_we),
    .waddr_i(AW'(cmd_index_i)),
    .wdata_i(cmd_coef_i),
    .raddr_i(ci_q),
    .rdata_o(cf_rdata)
  );

  always_comb begin
    if (tap_count_i == '0) begin
      taps = NW'(1);
    end else if (TW'(tap_count_i) > TW'(MAX_TAPS)) begin
      taps = NW'(MAX_TAPS);
    end else begin
      taps = NW'(tap_count_i);
    end
    start_sum = SW'(wp_q) + SW'(MAX_TAPS) - SW'(taps) + SW'(1);
    start     = (start_sum >= SW'(MAX_TAPS)) ? AW'(start_sum - SW'(MAX_TAPS))
                                             : AW'(start_sum);
  end

  always_comb begin
    rnd     = acc_q + (ACCW'(1) <<< (COEF_BITS - 2));
    rs      = rnd[ACCW-1:COEF_BITS-1];
    rs_top  = rs[RW-1:SAMPLE_BITS-1];
    sat_pos = !rs[RW-1] && (rs_top != '0);
    sat_neg = rs[RW-1] && (rs_top != '1);
    if (sat_pos) begin
      out_d = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    end else if (sat_neg) begin
      out_d = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    end else begin
      out_d = rs[SAMPLE_BITS-1:0];
    end
  end

  assign issue = (state_q == B_MAC);
  assign v1_d  = issue;
  assign m1_d  = wrap_q || (rd_q < wp_q);
  assign v2_d  = v1_q;

  always_comb begin
    prod_d = '0;
    if (m1_q) begin
      prod_d = $signed(dl_rdata) * $signed(cf_rdata);
    end
  end

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    wrap_d    = wrap_q;
    rd_d      = rd_q;
    ci_d      = ci_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    cmd_pop_o = 1'b0;
    dl_we     = 1'b0;
    cf_we     = 1'b0;
    load      = 1'b0;

    if (v2_q) begin
      acc_d = acc_q + ACCW'(prod_q);
    end

    case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_kind_i)
            CMD_COEF: begin
              cf_we = 1'b1;
            end
            CMD_SAMPLE, CMD_EMIT: begin
              dl_we = 1'b1;
              if (wp_q == AW'(MAX_TAPS - 1)) begin
                wp_d   = '0;
                wrap_d = 1'b1;
              end else begin
                wp_d = wp_q + AW'(1);
              end
              if (cmd_kind_i == CMD_EMIT) begin
                rd_d    = start;
                ci_d    = '0;
                cnt_d   = taps - NW'(1);
                acc_d   = '0;
                state_d = B_MAC;
              end
            end
            default: begin
            end
          endcase
        end
      end
      B_MAC: begin
        rd_d = (rd_q == AW'(MAX_TAPS - 1)) ? '0 : rd_q + AW'(1);
        ci_d = ci_q + AW'(1);
        if (cnt_q == '0) begin
          state_d = B_DRAIN;
        end else begin
          cnt_d = cnt_q - NW'(1);
        end
      end
      B_DRAIN: begin
        if (!v1_q && !v2_q) begin
          state_d = B_ROUND;
        end
      end
      B_ROUND: begin
        if (!res_q || pop_i) begin
          load    = 1'b1;
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  assign res_d   = load || (res_q && !pop_i);
  assign empty_o = !res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      wp_q    <= '0;
      wrap_q  <= 1'b0;
      cnt_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      res_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      wrap_q  <= wrap_d;
      cnt_q   <= cnt_d;
      v1_q    <= v1_d;
      v2_q    <= v2_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q   <= rd_d;
    ci_q   <= ci_d;
    m1_q   <= m1_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (load) begin
      sample_out_o <= out_d;
      saturated_o  <= sat_pos || sat_neg;
    end
  end

endmodule

`default_nettype wire

// File: sv/fir_fractional_decimator.sv
`default_nettype none

// Channel   Handshake            Payload
// input     push / full          req_type_i, coef_index_i, coef_value_i, sample_in_i
// result    empty / pop          sample_out_o, saturated_o
// config    cfg_we_i, cfg_idx_i  cfg_wdata_i (index 0 tap_count, 1 rate_step)
//
// A coefficient write or a sample that makes no output is handled in the back end's idle state.
// A sample that makes an output starts a pass in which one shared multiply-add
// walks the delay line and coefficient memories a tap per cycle.
// The front keeps the phase and feeds a four-entry command queue, so input is taken
// while the back end works; full rises only when that queue is full.
// Reset clears phase, write pointer and the queue; the delay line reads as zero until written.
// A waiting result stalls the next output, and commands queued behind that output wait with it.

module fir_fractional_decimator
  import fir_fd_pkg::*;
#(
  parameter int unsigned MAX_TAPS    = 512,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COEF_BITS   = 18
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          req_type_i,
  input  wire logic [COEF_INDEX_W-1:0]       coef_index_i,
  input  wire logic signed [COEF_BITS-1:0]   coef_value_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic signed [SAMPLE_BITS-1:0]      sample_out_o,
  output logic                               saturated_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]         cfg_wdata_i
);

  localparam int unsigned QW = 2 + COEF_INDEX_W + COEF_BITS + SAMPLE_BITS;

  logic [TAP_COUNT_W-1:0] tap_count_q;
  logic [RATE_STEP_W-1:0] rate_step_q;

  logic                          cmd_push, q_empty, cmd_pop;
  cmd_kind_e                     cmd_kind, q_kind;
  logic [QW-1:0]                 q_wdata, q_rdata;
  logic [COEF_INDEX_W-1:0]       q_index;
  logic signed [COEF_BITS-1:0]   q_coef;
  logic signed [SAMPLE_BITS-1:0] q_sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAP_COUNT_RST;
      rate_step_q <= RATE_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TAP_COUNT: tap_count_q <= cfg_wdata_i[TAP_COUNT_W-1:0];
        CFG_RATE_STEP: rate_step_q <= cfg_wdata_i[RATE_STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fir_fd_front #(.MAX_TAPS(MAX_TAPS)) u_front (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .full_i      (full),
    .req_type_i,
    .coef_index_i,
    .rate_step_i (rate_step_q),
    .cmd_push_o  (cmd_push),
    .cmd_kind_o  (cmd_kind)
  );

  assign q_wdata = {cmd_kind, coef_index_i, coef_value_i, sample_in_i};

  fir_fd_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i,
    .rst_ni,
    .push_i (cmd_push),
    .wdata_i(q_wdata),
    .full_o (full),
    .pop_i  (cmd_pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty)
  );

  assign q_kind   = cmd_kind_e'(q_rdata[QW-1 -: 2]);
  assign q_index  = q_rdata[QW-3 -: COEF_INDEX_W];
  assign q_coef   = q_rdata[SAMPLE_BITS +: COEF_BITS];
  assign q_sample = q_rdata[SAMPLE_BITS-1:0];

  fir_fd_back #(
    .MAX_TAPS   (MAX_TAPS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cmd_valid_i (!q_empty),
    .cmd_kind_i  (q_kind),
    .cmd_index_i (q_index),
    .cmd_coef_i  (q_coef),
    .cmd_sample_i(q_sample),
    .cmd_pop_o   (cmd_pop),
    .tap_count_i (tap_count_q),
    .pop_i       (pop),
    .empty_o     (empty),
    .sample_out_o,
    .saturated_o
  );

endmodule

`default_nettype wire
